@@ rtl/core/integer_to_ascii_radix_defines.svh @@
// Assertion helpers for the checker file.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define ITAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define ITAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/itar_pkg.sv @@
package itar_pkg;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned BinBits    = 32;
  localparam int unsigned DecDigits  = 10;
  localparam int unsigned OctDigits  = 11;
  localparam int unsigned Hex32Digits = 8;
  localparam int unsigned Hex64Digits = 16;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef enum logic [2:0] {
    KIND_SDEC  = 3'd0,
    KIND_UDEC  = 3'd1,
    KIND_OCT   = 3'd2,
    KIND_HEX32 = 3'd3,
    KIND_HEX64 = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [4:0] emitted_count;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic in_dec;
    logic conv_done;
    logic top_zero;
    logic rem_one;
    logic neg;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic lower);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CharZero + d8;
    end
    return (lower ? CharLowerA : CharUpperA) + d8 - 8'd10;
  endfunction

endpackage

@@ rtl/core/integer_to_ascii_radix.sv @@
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_ready_o in_req_i  (kind, value)
// out      output     out_valid_o/out_ready_i out_rsp_o (character, last, emitted_count)
//
// One request at a time. Decimal kinds run a 32-step double dabble loop after
// the accept, then skip leading zeros one at a time (up to 9), then emit the
// characters one at a time. Octal and hex skip leading zeros directly, one at a
// time (up to 15), then emit the characters. Reset clears the controller and
// output valid only.
// A stalled output holds the controller; a new request is taken once the last
// character of the previous one is in the output register.
module integer_to_ascii_radix import itar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  itar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itar_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ rtl/core/itar_ctrl.sv @@
module itar_ctrl import itar_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // Requests with an unused kind are taken and dropped.
        if (in_valid_i && sts_i.kind_ok) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_dec ? ST_CONVERT : ST_SKIP;
        end
      end
      ST_CONVERT: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.rem_one) begin
          cmd_o.skip_shift = 1'b1;
        end else begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/itar_dpath.sv @@
module itar_dpath import itar_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  cmd_t     cmd_i,
  output sts_t     sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned SlotBits = 4 * NumSlots;
  localparam int unsigned BcdBits  = 4 * DecDigits;
  localparam int unsigned BcdLow   = SlotBits - BcdBits;
  localparam int unsigned OctLow   = NumSlots - OctDigits;

  // Digits stay left-justified: the next character is always the top slot.
  logic [SlotBits-1:0] dig_q, dig_d;
  logic [BinBits-1:0]  bin_q, bin_d;
  logic [4:0]          bitcnt_q, bitcnt_d;
  logic [4:0]          rem_q, rem_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic                lower_q, lower_d;
  logic                out_valid_q, out_valid_d;
  out_rsp_t            out_rsp_q, out_rsp_d;

  logic [31:0]         low32;
  logic [BinBits-1:0]  mag;
  logic [SlotBits-1:0] oct_slots;
  logic [BcdBits-1:0]  bcd_adj;
  logic [3:0]          nib;
  logic                kind_ok;
  logic                in_dec;

  assign low32 = in_req_i.value[31:0];
  assign mag   = low32[31] ? (~low32 + 32'd1) : low32;

  always_comb begin
    oct_slots = '0;
    for (int i = 0; i < OctDigits - 1; i++) begin
      oct_slots[4*(OctLow+i) +: 4] = {1'b0, low32[3*i +: 3]};
    end
    oct_slots[SlotBits-1 -: 4] = {2'b00, low32[31:30]};
  end

  always_comb begin
    kind_ok = 1'b1;
    in_dec  = 1'b0;
    unique case (kind_e'(in_req_i.kind))
      KIND_SDEC, KIND_UDEC: in_dec = 1'b1;
      KIND_OCT, KIND_HEX32, KIND_HEX64: in_dec = 1'b0;
      default: kind_ok = 1'b0;
    endcase
  end

  // Double dabble correction on the ten BCD digits before each shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      nib = dig_q[BcdLow + 4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    dig_d       = dig_q;
    bin_d       = bin_q;
    bitcnt_d    = bitcnt_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    lower_d     = lower_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      cnt_d    = '0;
      bitcnt_d = '0;
      neg_d    = 1'b0;
      lower_d  = 1'b0;
      dig_d    = '0;
      bin_d    = low32;
      unique case (kind_e'(in_req_i.kind))
        KIND_SDEC: begin
          neg_d = low32[31];
          bin_d = mag;
          rem_d = 5'(DecDigits);
        end
        KIND_UDEC: begin
          rem_d = 5'(DecDigits);
        end
        KIND_OCT: begin
          dig_d = oct_slots;
          rem_d = 5'(OctDigits);
        end
        KIND_HEX32: begin
          dig_d = {low32, 32'd0};
          rem_d = 5'(Hex32Digits);
        end
        KIND_HEX64: begin
          dig_d   = in_req_i.value;
          lower_d = 1'b1;
          rem_d   = 5'(Hex64Digits);
        end
        default: begin
          rem_d = rem_q;
        end
      endcase
    end

    if (cmd_i.conv_step) begin
      dig_d[SlotBits-1:BcdLow] = {bcd_adj[BcdBits-2:0], bin_q[BinBits-1]};
      bin_d    = {bin_q[BinBits-2:0], 1'b0};
      bitcnt_d = bitcnt_q + 5'd1;
    end

    if (cmd_i.skip_shift) begin
      dig_d = {dig_q[SlotBits-5:0], 4'd0};
      rem_d = rem_q - 5'd1;
    end

    if (cmd_i.emit_sign) begin
      out_rsp_d.character     = CharMinus;
      out_rsp_d.last          = 1'b0;
      out_rsp_d.emitted_count = cnt_q + 5'd1;
      cnt_d                   = cnt_q + 5'd1;
      out_valid_d             = 1'b1;
    end

    if (cmd_i.emit_digit) begin
      out_rsp_d.character     = digit_char(dig_q[SlotBits-1 -: 4], lower_q);
      out_rsp_d.last          = (rem_q == 5'd1);
      out_rsp_d.emitted_count = cnt_q + 5'd1;
      cnt_d                   = cnt_q + 5'd1;
      dig_d                   = {dig_q[SlotBits-5:0], 4'd0};
      rem_d                   = rem_q - 5'd1;
      out_valid_d             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q     <= dig_d;
    bin_q     <= bin_d;
    bitcnt_q  <= bitcnt_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    lower_q   <= lower_d;
    out_rsp_q <= out_rsp_d;
  end

  assign sts_o.kind_ok   = kind_ok;
  assign sts_o.in_dec    = in_dec;
  assign sts_o.conv_done = (bitcnt_q == 5'(BinBits - 1));
  assign sts_o.top_zero  = (dig_q[SlotBits-1 -: 4] == 4'd0);
  assign sts_o.rem_one   = (rem_q == 5'd1);
  assign sts_o.neg       = neg_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/core/itar_checker.sv @@
`include "integer_to_ascii_radix_defines.svh"

module itar_checker import itar_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_o
);

  `ITAR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o), "output changed while stalled")

  // Characters of one number follow each other without a gap.
  `ITAR_ASSERT(a_no_gap, out_valid_o && out_ready_i && !out_rsp_o.last |=> out_valid_o, "gap inside a number")

  // No new request while a number is still being emitted.
  `ITAR_ASSERT(a_busy, out_valid_o && !out_rsp_o.last |-> !in_ready_o, "request taken mid-number")

  `ITAR_ASSERT(a_count, out_valid_o |-> out_rsp_o.emitted_count != 5'd0, "zero character count")

  `ITAR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind integer_to_ascii_radix itar_checker u_itar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import itar_pkg::*;

  localparam logic [2:0] KindLastUnused = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_request = 0;
  int       hold_left = 0;
  int       fail_count = 0;
  out_rsp_t expected_chars[$];
  out_rsp_t want;

  integer_to_ascii_radix dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the characters one request should produce and queues them.
  function automatic void predict_digits(in_req_t req);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic [31:0] low32;
    logic [7:0]  digit_chars[$];
    logic        minus;
    logic        lower;
    int          total;
    int          pos;
    out_rsp_t    rsp;

    low32 = req.value[31:0];
    minus = 1'b0;
    lower = 1'b0;
    mag = {32'b0, low32};
    case (req.kind)
      KIND_SDEC: begin
        radix = 64'd10;
        if (low32[31]) begin
          // The magnitude is taken in 33 bits so the most negative int comes out right.
          minus = 1'b1;
          mag = 64'h1_0000_0000 - {32'b0, low32};
        end
      end
      KIND_UDEC:  radix = 64'd10;
      KIND_OCT:   radix = 64'd8;
      KIND_HEX32: radix = 64'd16;
      KIND_HEX64: begin
        radix = 64'd16;
        lower = 1'b1;
        mag = req.value;
      end
      default: return;
    endcase

    do begin
      rem = mag % radix;
      if (rem < 64'd10) begin
        digit_chars.push_front(CharZero + {4'b0, rem[3:0]});
      end else begin
        digit_chars.push_front((lower ? CharLowerA : CharUpperA) + {4'b0, rem[3:0]} - 8'd10);
      end
      mag = mag / radix;
    end while (mag != 64'd0);

    if (minus) begin
      digit_chars.push_front(CharMinus);
    end
    total = digit_chars.size();
    for (pos = 0; pos < total; pos++) begin
      rsp.character = digit_chars[pos];
      rsp.last = (pos + 1 == total);
      rsp.emitted_count = 5'(pos + 1);
      expected_chars.push_back(rsp);
    end
  endfunction

  task automatic send_number(input logic [2:0] kind, input logic [63:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{kind: kind, value: value};
    do @(posedge clk); while (!in_ready);
    predict_digits('{kind: kind, value: value});
  endtask

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("character: expected none, got %h", out_rsp.character);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_rsp.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, out_rsp.character);
          fail_count++;
        end
        if (out_rsp.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_rsp.last);
          fail_count++;
        end
        if (out_rsp.emitted_count !== want.emitted_count) begin
          $error("emitted_count: expected %0d, got %0d", want.emitted_count,
                 out_rsp.emitted_count);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_number(KIND_SDEC, 64'd0);
    send_number(KIND_SDEC, 64'd1);
    send_number(KIND_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(KIND_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_number(KIND_SDEC, 64'h0000_0000_8000_0000);
    send_number(KIND_SDEC, 64'hDEAD_BEEF_0000_007B);
    send_number(KIND_UDEC, 64'd0);
    send_number(KIND_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(KIND_UDEC, 64'hFFFF_FFFF_3B9A_CA00);
    send_number(KIND_UDEC, 64'd9);
    send_number(KIND_OCT, 64'd0);
    send_number(KIND_OCT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(KIND_OCT, 64'd8);
    send_number(KIND_HEX32, 64'd0);
    send_number(KIND_HEX32, 64'h0000_0000_FFFF_FFFF);
    send_number(KIND_HEX32, 64'hFFFF_FFFF_ABCD_EF01);
    send_number(KIND_HEX64, 64'd0);
    send_number(KIND_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(KIND_HEX64, 64'h8000_0000_0000_0000);
    send_number(KIND_HEX64, 64'h0123_4567_89AB_CDEF);
    send_number(3'(KIND_HEX64 + 1), 64'h1234_5678_9ABC_DEF0);
    send_number(3'(KIND_HEX64 + 2), 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(KindLastUnused, 64'd0);
    send_number(KIND_SDEC, 64'h0000_0000_8000_0001);
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    logic [2:0]  kind;
    logic [63:0] value;

    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      // A random shift gives numbers of every length, not only the longest.
      value = {$urandom(), $urandom()} >> $urandom_range(63, 0);
      if ($urandom_range(19) == 0) begin
        kind = 3'($urandom_range(KindLastUnused, KIND_HEX64 + 1));
      end else begin
        kind = 3'($urandom_range(KIND_HEX64, KIND_SDEC));
      end
      send_number(kind, value);
    end
  endtask

  // The receiver stops for a long while so the block backs up into its input.
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    hold_request = 300;
    send_number(KIND_HEX64, {$urandom(), $urandom()} | 64'h8000_0000_0000_0000);
    repeat (8) begin
      send_number(3'($urandom_range(KIND_HEX64, KIND_SDEC)), {$urandom(), $urandom()});
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(35, 0, 0);
    test_random(35, 55, 0);
    test_random(35, 0, 55);
    test_random(35, 33, 33);
    test_receiver_hold();
    test_random(10, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ integer_to_ascii_radix.f @@
+incdir+rtl/core
rtl/core/itar_pkg.sv
rtl/core/itar_ctrl.sv
rtl/core/itar_dpath.sv
rtl/core/integer_to_ascii_radix.sv
rtl/core/itar_checker.sv
verif/testbench.sv
